// ===== rtl/sbck_pkg.sv =====
// Shared constants, codes and control structs for the scaled sprite blit engine.
// No dependencies; every other file of the block uses this package.
package sbck_pkg;

	// Framebuffer and texture limits.
	localparam int FB_WIDTH    = 1024;
	localparam int FB_HEIGHT   = 768;
	localparam int TEX_DIM_MAX = 64;

	// Field widths of the words and registers.
	localparam int COLOR_W = 32;
	localparam int COORD_W = 12;
	localparam int OFS_W   = 11;
	localparam int TEXD_W  = 7;
	localparam int ADDR_W  = 12;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam int MODE_W  = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Sample coordinates stay below the clamped texture size.
	localparam int QUO_W  = $clog2(TEX_DIM_MAX);
	localparam int DVD_W  = OFS_W + QUO_W;
	localparam int DCNT_W = $clog2(QUO_W + 1);

	// Magenta texels are transparent.
	localparam logic [COLOR_W-1:0] COLOR_KEY = 32'h00FF_00FF;

	// Draw modes.
	localparam logic [MODE_W-1:0] MODE_FILL   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BORDER = 2'd1;
	localparam logic [MODE_W-1:0] MODE_IMAGE  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_QUAD_W     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_QUAD_H     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_W      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_H      = 3'd7;

	// Input command codes.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	// Source of the result word.
	localparam logic [1:0] OSEL_NONE = 2'd0;
	localparam logic [1:0] OSEL_FILL = 2'd1;
	localparam logic [1:0] OSEL_TEX  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       capture;
		logic       mem_wr;
		logic       div_start;
		logic       div_sel_y;
		logic       lat_sx;
		logic       lat_sy;
		logic       lat_addr;
		logic       mem_rd;
		logic       load_out;
		logic [1:0] osel;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic              is_load;
		logic              pass;
		logic [MODE_W-1:0] mode;
		logic              border;
		logic              div_done;
		logic              out_free;
	} dp_stat_t;

endpackage

// ===== rtl/sbck_in_if.sv =====
// Input channel of the blit engine: load and draw words with valid/ready.
// Depends on sbck_pkg for the field widths.
interface sbck_in_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic [sbck_pkg::ADDR_W-1:0]   texel_index;
	logic [sbck_pkg::COLOR_W-1:0]  texel_word;
	logic [sbck_pkg::OFS_W-1:0]    offset_x;
	logic [sbck_pkg::OFS_W-1:0]    offset_y;

	modport source (output valid, cmd, texel_index, texel_word, offset_x, offset_y,
		input ready);
	modport sink (input valid, cmd, texel_index, texel_word, offset_x, offset_y,
		output ready);
endinterface

// ===== rtl/sbck_out_if.sv =====
// Output channel of the blit engine: framebuffer write words with valid/ready.
// Depends on sbck_pkg for the field widths.
interface sbck_out_if;
	logic                          valid;
	logic                          ready;
	logic                          write_enable;
	logic [sbck_pkg::OFS_W-1:0]    fb_x;
	logic [sbck_pkg::OFS_W-1:0]    fb_y;
	logic [sbck_pkg::COLOR_W-1:0]  pixel_color;

	modport source (output valid, write_enable, fb_x, fb_y, pixel_color, input ready);
	modport sink (input valid, write_enable, fb_x, fb_y, pixel_color, output ready);
endinterface

// ===== rtl/scaled_sprite_blit_color_key_core.sv =====
// Scaled sprite blit with color key: one result word per input word.
// A load or fill/border draw goes through the evaluate and done states to the output
// register; a texture draw adds two 6-step divisions in the shared divider, then the
// address and read states. One word at a time; done waits while the output is full.
// Reset (arst_n low) clears control state and sets config registers to defaults;
// the texture store is not cleared and holds garbage until loaded.
module scaled_sprite_blit_color_key_core (
	input  logic                           clk,
	input  logic                           arst_n,
	sbck_in_if.sink                        in_ch,
	sbck_out_if.source                     out_ch,
	input  logic                           cfg_we,
	input  logic [sbck_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [sbck_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sbck_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// Sequencer.
	sbck_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath.
	sbck_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_data         (cfg_data),
		.in_cmd           (in_ch.cmd),
		.in_texel_index   (in_ch.texel_index),
		.in_texel_word    (in_ch.texel_word),
		.in_offset_x      (in_ch.offset_x),
		.in_offset_y      (in_ch.offset_y),
		.out_ready        (out_ch.ready),
		.out_valid        (out_ch.valid),
		.out_write_enable (out_ch.write_enable),
		.out_fb_x         (out_ch.fb_x),
		.out_fb_y         (out_ch.fb_y),
		.out_pixel_color  (out_ch.pixel_color),
		.cmd              (cmd),
		.stat             (stat)
	);
endmodule

// ===== rtl/sbck_div.sv =====
// Restoring divider producing the sample coordinate, one quotient bit per cycle.
// Depends on sbck_pkg; the quotient is known to fit in QUO_W bits.
module sbck_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sbck_pkg::DVD_W-1:0]  dividend,
	input  logic [sbck_pkg::OFS_W-1:0]  divisor,
	output logic                        done,
	output logic [sbck_pkg::QUO_W-1:0]  quotient
);
	import sbck_pkg::*;

	logic [DVD_W-1:0]  rem_q;
	logic [DVD_W-1:0]  dsh_q;
	logic [QUO_W-1:0]  quot_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              ge;

	// Trial subtract of the shifted divisor.
	assign ge = rem_q >= dsh_q;

	// Control: step counter and one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DCNT_W'(QUO_W);
		end else begin
			done_q <= busy_q && (cnt_q == DCNT_W'(1));
			if (busy_q) begin
				cnt_q <= cnt_q - DCNT_W'(1);
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: partial remainder, shifted divisor and quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsh_q  <= DVD_W'(divisor) << (QUO_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[QUO_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;
endmodule

// ===== rtl/sbck_ctrl.sv =====
// Sequencing state machine of the blit engine; drives datapath commands.
// Depends on sbck_pkg for the command and status structs.
module sbck_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sbck_pkg::dp_stat_t    stat,
	output sbck_pkg::ctrl_cmd_t   cmd
);
	import sbck_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_DIVX = 3'd2;
	localparam logic [2:0] S_DIVY = 3'd3;
	localparam logic [2:0] S_ADDR = 3'd4;
	localparam logic [2:0] S_READ = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] osel_q;
	logic [1:0] osel_d;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		osel_d  = osel_q;
		cmd     = '0;
		cmd.osel = osel_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				state_d = S_DONE;
				osel_d  = OSEL_NONE;
				if (stat.is_load) begin
					cmd.mem_wr = 1'b1;
				end else if (stat.pass) begin
					unique case (stat.mode)
						MODE_FILL: osel_d = OSEL_FILL;
						MODE_BORDER: osel_d = stat.border ? OSEL_FILL : OSEL_NONE;
						MODE_IMAGE: begin
							osel_d        = OSEL_TEX;
							cmd.div_start = 1'b1;
							state_d       = S_DIVX;
						end
						default: osel_d = OSEL_NONE;
					endcase
				end
			end
			S_DIVX: begin
				if (stat.div_done) begin
					cmd.lat_sx    = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel_y = 1'b1;
					state_d       = S_DIVY;
				end
			end
			S_DIVY: begin
				if (stat.div_done) begin
					cmd.lat_sy = 1'b1;
					state_d    = S_ADDR;
				end
			end
			S_ADDR: begin
				cmd.lat_addr = 1'b1;
				state_d      = S_READ;
			end
			S_READ: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			osel_q  <= OSEL_NONE;
		end else begin
			state_q <= state_d;
			osel_q  <= osel_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);
endmodule

// ===== rtl/sbck_dp.sv =====
// Datapath of the blit engine: configuration registers, input capture, texture
// store, shared divider and the output register. Depends on sbck_pkg, sbck_div.
module sbck_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sbck_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [sbck_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_cmd,
	input  logic [sbck_pkg::ADDR_W-1:0]    in_texel_index,
	input  logic [sbck_pkg::COLOR_W-1:0]   in_texel_word,
	input  logic [sbck_pkg::OFS_W-1:0]     in_offset_x,
	input  logic [sbck_pkg::OFS_W-1:0]     in_offset_y,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic                           out_write_enable,
	output logic [sbck_pkg::OFS_W-1:0]     out_fb_x,
	output logic [sbck_pkg::OFS_W-1:0]     out_fb_y,
	output logic [sbck_pkg::COLOR_W-1:0]   out_pixel_color,
	input  sbck_pkg::ctrl_cmd_t            cmd,
	output sbck_pkg::dp_stat_t             stat
);
	import sbck_pkg::*;

	// Configuration registers.
	logic [MODE_W-1:0]         mode_q;
	logic [COLOR_W-1:0]        fill_q;
	logic signed [COORD_W-1:0] org_x_q;
	logic signed [COORD_W-1:0] org_y_q;
	logic [OFS_W-1:0]          quad_w_q;
	logic [OFS_W-1:0]          quad_h_q;
	logic [TEXD_W-1:0]         tex_w_q;
	logic [TEXD_W-1:0]         tex_h_q;

	// Captured input word.
	logic               ld_cmd_q;
	logic [ADDR_W-1:0]  ld_idx_q;
	logic [COLOR_W-1:0] ld_word_q;
	logic [OFS_W-1:0]   dx_q;
	logic [OFS_W-1:0]   dy_q;

	// Sampling state.
	logic [QUO_W-1:0]   sx_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [COLOR_W-1:0] rd_q;
	logic [COLOR_W-1:0] store [STORE_DEPTH];

	// Output register.
	logic               ov_q;
	logic               owe_q;
	logic [OFS_W-1:0]   ofx_q;
	logic [OFS_W-1:0]   ofy_q;
	logic [COLOR_W-1:0] ocol_q;

	logic [TEXD_W-1:0]         tw_eff;
	logic [TEXD_W-1:0]         th_eff;
	logic signed [COORD_W:0]   px;
	logic signed [COORD_W:0]   py;
	logic                      in_quad;
	logic                      on_fb;
	logic [OFS_W-1:0]          div_num;
	logic [TEXD_W-1:0]         div_dim;
	logic [OFS_W+TEXD_W-1:0]   div_prod;
	logic [OFS_W-1:0]          div_den;
	logic                      div_done;
	logic [QUO_W-1:0]          div_quo;
	logic [QUO_W+TEXD_W-1:0]   row_base;
	logic                      tex_we;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_FILL;
			fill_q   <= '0;
			org_x_q  <= '0;
			org_y_q  <= '0;
			quad_w_q <= '0;
			quad_h_q <= '0;
			tex_w_q  <= TEXD_W'(1);
			tex_h_q  <= TEXD_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DRAW_MODE:  mode_q   <= cfg_data[MODE_W-1:0];
				REG_FILL_COLOR: fill_q   <= cfg_data[COLOR_W-1:0];
				REG_ORIGIN_X:   org_x_q  <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Y:   org_y_q  <= cfg_data[COORD_W-1:0];
				REG_QUAD_W:     quad_w_q <= cfg_data[OFS_W-1:0];
				REG_QUAD_H:     quad_h_q <= cfg_data[OFS_W-1:0];
				REG_TEX_W:      tex_w_q  <= cfg_data[TEXD_W-1:0];
				REG_TEX_H:      tex_h_q  <= cfg_data[TEXD_W-1:0];
				default: ;
			endcase
		end
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ld_cmd_q  <= in_cmd;
			ld_idx_q  <= in_texel_index;
			ld_word_q <= in_texel_word;
			dx_q      <= in_offset_x;
			dy_q      <= in_offset_y;
		end
	end

	// Texture size clamp: zero acts as one, large values saturate.
	always_comb begin
		priority if (tex_w_q == '0) tw_eff = TEXD_W'(1);
		else if (tex_w_q > TEXD_W'(TEX_DIM_MAX)) tw_eff = TEXD_W'(TEX_DIM_MAX);
		else tw_eff = tex_w_q;
		priority if (tex_h_q == '0) th_eff = TEXD_W'(1);
		else if (tex_h_q > TEXD_W'(TEX_DIM_MAX)) th_eff = TEXD_W'(TEX_DIM_MAX);
		else th_eff = tex_h_q;
	end

	// Destination position and clipping.
	assign px = $signed({org_x_q[COORD_W-1], org_x_q}) + $signed({2'b00, dx_q});
	assign py = $signed({org_y_q[COORD_W-1], org_y_q}) + $signed({2'b00, dy_q});
	assign in_quad = (dx_q < quad_w_q) && (dy_q < quad_h_q);
	assign on_fb = !px[COORD_W] && (px[COORD_W-1:0] < COORD_W'(FB_WIDTH)) &&
		!py[COORD_W] && (py[COORD_W-1:0] < COORD_W'(FB_HEIGHT));

	// Divider operands: offset times texture size over quad size.
	assign div_num  = cmd.div_sel_y ? dy_q : dx_q;
	assign div_dim  = cmd.div_sel_y ? th_eff : tw_eff;
	assign div_den  = cmd.div_sel_y ? quad_h_q : quad_w_q;
	assign div_prod = div_num * div_dim;

	sbck_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_prod[DVD_W-1:0]),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Sample address, row-major and wrapped to the store depth.
	assign row_base = div_quo * tw_eff;
	always_ff @(posedge clk) begin
		if (cmd.lat_sx) begin
			sx_q <= div_quo;
		end
		if (cmd.lat_sy) begin
			addr_q <= row_base[ADDR_W-1:0] + ADDR_W'(sx_q);
		end
	end

	// Texture store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			store[ld_idx_q] <= ld_word_q;
		end
		if (cmd.mem_rd) begin
			rd_q <= store[addr_q];
		end
	end

	assign tex_we = (rd_q != COLOR_KEY);

	// Output register; fields are zero when no write is made.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.load_out) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			owe_q  <= 1'b0;
			ofx_q  <= '0;
			ofy_q  <= '0;
			ocol_q <= '0;
			unique case (cmd.osel)
				OSEL_FILL: begin
					owe_q  <= 1'b1;
					ofx_q  <= px[OFS_W-1:0];
					ofy_q  <= py[OFS_W-1:0];
					ocol_q <= fill_q;
				end
				OSEL_TEX: begin
					if (tex_we) begin
						owe_q  <= 1'b1;
						ofx_q  <= px[OFS_W-1:0];
						ofy_q  <= py[OFS_W-1:0];
						ocol_q <= rd_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Status for the controller.
	always_comb begin
		stat          = '0;
		stat.is_load  = (ld_cmd_q == CMD_LOAD);
		stat.pass     = in_quad && on_fb;
		stat.mode     = mode_q;
		stat.border   = (dx_q == '0) || (dy_q == '0) ||
			(dx_q == quad_w_q - OFS_W'(1)) || (dy_q == quad_h_q - OFS_W'(1));
		stat.div_done = div_done;
		stat.out_free = !ov_q || out_ready;
	end

	assign out_valid        = ov_q;
	assign out_write_enable = owe_q;
	assign out_fb_x         = ofx_q;
	assign out_fb_y         = ofy_q;
	assign out_pixel_color  = ocol_q;
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for scaled_sprite_blit_color_key_core: directed and random
// load/draw words, predicted in-bench and compared word by word at the output.
// Depends on sbck_pkg, sbck_in_if, sbck_out_if and the core itself.
module tb_top;
	import sbck_pkg::*;

	localparam int RANDOM_WORDS = 1950;
	localparam int SETTLE_CYCLES = 24;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic               cmd;
		logic [ADDR_W-1:0]  texel_index;
		logic [COLOR_W-1:0] texel_word;
		logic [OFS_W-1:0]   offset_x;
		logic [OFS_W-1:0]   offset_y;
	} blit_word_t;

	typedef struct packed {
		logic               we;
		logic [OFS_W-1:0]   fb_x;
		logic [OFS_W-1:0]   fb_y;
		logic [COLOR_W-1:0] color;
	} fb_write_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	sbck_in_if in_ch ();
	sbck_out_if out_ch ();

	scaled_sprite_blit_color_key_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Register shadow, texture mirror and the queues between the processes.
	logic [MODE_W-1:0]         mode_r = MODE_FILL;
	logic [COLOR_W-1:0]        fill_r = '0;
	logic signed [COORD_W-1:0] org_x_r = '0;
	logic signed [COORD_W-1:0] org_y_r = '0;
	logic [OFS_W-1:0]          quad_w_r = '0;
	logic [OFS_W-1:0]          quad_h_r = '0;
	logic [TEXD_W-1:0]         tex_w_r = TEXD_W'(1);
	logic [TEXD_W-1:0]         tex_h_r = TEXD_W'(1);

	logic [COLOR_W-1:0] tex_mirror [STORE_DEPTH];
	bit                 gen_loaded [STORE_DEPTH];

	blit_word_t pending_words[$];
	fb_write_t  exp_writes[$];
	blit_word_t cur_word;
	int words_queued = 0;
	int mismatch_count = 0;
	int results_seen = 0;

	// Texel address for a pixel, with both texture sizes clamped to 1..TEX_DIM_MAX.
	function automatic logic [ADDR_W-1:0] sample_addr(input int dx, input int dy);
		int tw, th;
		tw = (tex_w_r == 0) ? 1 : (tex_w_r > TEX_DIM_MAX) ? TEX_DIM_MAX : int'(tex_w_r);
		th = (tex_h_r == 0) ? 1 : (tex_h_r > TEX_DIM_MAX) ? TEX_DIM_MAX : int'(tex_h_r);
		return ADDR_W'(((dy * th) / int'(quad_h_r)) * tw + (dx * tw) / int'(quad_w_r));
	endfunction

	// Framebuffer write that one accepted word should produce.
	function automatic fb_write_t render_word(input blit_word_t w);
		fb_write_t r;
		int px, py, dx, dy;
		logic [COLOR_W-1:0] texel;
		logic hit;
		r = '0;
		hit = 1'b0;
		texel = '0;
		dx = int'(w.offset_x);
		dy = int'(w.offset_y);
		if (w.cmd == CMD_LOAD) begin
			tex_mirror[w.texel_index] = w.texel_word;
			return r;
		end
		if (dx >= int'(quad_w_r) || dy >= int'(quad_h_r))
			return r;
		px = int'(org_x_r) + dx;
		py = int'(org_y_r) + dy;
		if (px < 0 || px >= FB_WIDTH || py < 0 || py >= FB_HEIGHT)
			return r;
		case (mode_r)
			MODE_FILL: begin
				texel = fill_r;
				hit = 1'b1;
			end
			MODE_BORDER: begin
				if (dx == 0 || dy == 0 || dx == int'(quad_w_r) - 1 || dy == int'(quad_h_r) - 1) begin
					texel = fill_r;
					hit = 1'b1;
				end
			end
			MODE_IMAGE: begin
				texel = tex_mirror[sample_addr(dx, dy)];
				hit = (texel != COLOR_KEY);
			end
			default: hit = 1'b0;
		endcase
		if (hit) begin
			r.we = 1'b1;
			r.fb_x = OFS_W'(px);
			r.fb_y = OFS_W'(py);
			r.color = texel;
		end
		return r;
	endfunction

	// Texel contents: mostly random, now and then the transparent key.
	function automatic logic [COLOR_W-1:0] random_texel();
		return ($urandom_range(0, 7) == 0) ? COLOR_KEY : COLOR_W'($urandom);
	endfunction

	function automatic void queue_load(input logic [ADDR_W-1:0] idx,
		input logic [COLOR_W-1:0] word);
		blit_word_t w;
		w.cmd = CMD_LOAD;
		w.texel_index = idx;
		w.texel_word = word;
		w.offset_x = OFS_W'($urandom);
		w.offset_y = OFS_W'($urandom);
		pending_words.push_back(w);
		gen_loaded[idx] = 1'b1;
		words_queued++;
	endfunction

	// A texture draw inside the quad is preceded by a load whenever its texel was never written.
	function automatic void queue_draw(input int dx, input int dy);
		blit_word_t w;
		logic [ADDR_W-1:0] a;
		if (mode_r == MODE_IMAGE && dx < int'(quad_w_r) && dy < int'(quad_h_r)) begin
			a = sample_addr(dx, dy);
			if (!gen_loaded[a])
				queue_load(a, random_texel());
		end
		w.cmd = CMD_DRAW;
		w.texel_index = ADDR_W'($urandom);
		w.texel_word = COLOR_W'($urandom);
		w.offset_x = OFS_W'(dx);
		w.offset_y = OFS_W'(dy);
		pending_words.push_back(w);
		words_queued++;
	endfunction

	// Register write; the shadow follows the same field masks as the block.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		case (idx)
			REG_DRAW_MODE:  mode_r = data[MODE_W-1:0];
			REG_FILL_COLOR: fill_r = data[COLOR_W-1:0];
			REG_ORIGIN_X:   org_x_r = data[COORD_W-1:0];
			REG_ORIGIN_Y:   org_y_r = data[COORD_W-1:0];
			REG_QUAD_W:     quad_w_r = data[OFS_W-1:0];
			REG_QUAD_H:     quad_h_r = data[OFS_W-1:0];
			REG_TEX_W:      tex_w_r = data[TEXD_W-1:0];
			REG_TEX_H:      tex_h_r = data[TEXD_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sender holds off until every queued word is accepted and every result is back.
	task automatic drain();
		while (pending_words.size() != 0 || in_ch.valid || exp_writes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Driver: bursts of words separated by random gaps; a word is held until taken.
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				exp_writes.push_back(render_word(cur_word));
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					cur_word = pending_words.pop_front();
					in_ch.cmd <= cur_word.cmd;
					in_ch.texel_index <= cur_word.texel_index;
					in_ch.texel_word <= cur_word.texel_word;
					in_ch.offset_x <= cur_word.offset_x;
					in_ch.offset_y <= cur_word.offset_y;
					in_ch.valid <= 1'b1;
					if (burst_left <= 1) begin
						if ($urandom_range(0, 5) == 0) begin
							burst_left = 64;
							gap_left = 0;
						end else begin
							burst_left = $urandom_range(1, 12);
							gap_left = $urandom_range(0, 8);
						end
					end else begin
						burst_left--;
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result word against the oldest prediction, and
	// moves between stall styles of its own.
	int stall_style = 0;
	int style_left = 0;
	int stall_left = 0;
	int tick = 0;

	always @(posedge clk or negedge arst_n) begin
		fb_write_t got, want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			style_left = 0;
			stall_left = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got.we = out_ch.write_enable;
				got.fb_x = out_ch.fb_x;
				got.fb_y = out_ch.fb_y;
				got.color = out_ch.pixel_color;
				results_seen++;
				if (exp_writes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("result word %0d arrived with no prediction waiting", results_seen);
				end else begin
					want = exp_writes.pop_front();
					if (got.we !== want.we || got.fb_x !== want.fb_x ||
						got.fb_y !== want.fb_y || got.color !== want.color) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$write("result word %0d: expected we=%0b x=%0d y=%0d color=%08h,",
								results_seen, want.we, want.fb_x, want.fb_y, want.color);
							$display(" got we=%0b x=%0d y=%0d color=%08h",
								got.we, got.fb_x, got.fb_y, got.color);
						end
					end
				end
			end
			if (style_left == 0) begin
				stall_style = $urandom_range(0, 3);
				style_left = $urandom_range(50, 300);
			end else begin
				style_left--;
			end
			tick++;
			case (stall_style)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 3) != 0);
				2: out_ch.ready <= (tick % 5 == 0);
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						out_ch.ready <= 1'b0;
					end else begin
						if ($urandom_range(0, 15) == 0)
							stall_left = $urandom_range(1, 20);
						out_ch.ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// Watchdog: ends the run when no word moves on either side for too long.
	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Stimulus: reset, directed phases, then random register settings and words.
	initial begin : stimulus
		int directed_words, n_items, dx, dy, pick;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_LOAD;
		in_ch.texel_index = '0;
		in_ch.texel_word = '0;
		in_ch.offset_x = '0;
		in_ch.offset_y = '0;
		out_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: the quad is empty, so draws write nothing.
		queue_load('0, 32'h0000_0000);
		queue_load({ADDR_W{1'b1}}, 32'hFFFF_FFFF);
		queue_draw(0, 0);
		queue_draw(2047, 2047);
		drain();

		// Fill over a quad larger than the framebuffer, probing its edges.
		write_reg(REG_DRAW_MODE, CFG_DATA_W'(MODE_FILL));
		write_reg(REG_FILL_COLOR, 32'hA5C3_5A3C);
		write_reg(REG_QUAD_W, 32'd2047);
		write_reg(REG_QUAD_H, 32'd2047);
		queue_draw(0, 0);
		queue_draw(1023, 767);
		queue_draw(1024, 0);
		queue_draw(0, 768);
		queue_draw(2046, 2046);
		drain();

		// Border of a small quad in the bottom-right corner, inside and on the ring.
		write_reg(REG_DRAW_MODE, CFG_DATA_W'(MODE_BORDER));
		write_reg(REG_ORIGIN_X, 32'd1020);
		write_reg(REG_ORIGIN_Y, 32'd764);
		write_reg(REG_QUAD_W, 32'd4);
		write_reg(REG_QUAD_H, 32'd4);
		queue_draw(0, 0);
		queue_draw(1, 1);
		queue_draw(3, 3);
		queue_draw(3, 1);
		drain();

		// The spare mode code draws nothing.
		write_reg(REG_DRAW_MODE, CFG_DATA_W'(MODE_UNUSED));
		queue_draw(1, 1);
		drain();

		// Texture sizes of zero and above the maximum, and a keyed texel.
		write_reg(REG_DRAW_MODE, CFG_DATA_W'(MODE_IMAGE));
		write_reg(REG_ORIGIN_X, 32'd0);
		write_reg(REG_ORIGIN_Y, 32'd0);
		write_reg(REG_QUAD_W, 32'd2);
		write_reg(REG_QUAD_H, 32'd2);
		write_reg(REG_TEX_W, 32'd0);
		write_reg(REG_TEX_H, 32'd127);
		queue_load('0, COLOR_KEY);
		queue_load(ADDR_W'(32), 32'h1234_5678);
		queue_draw(0, 0);
		queue_draw(1, 1);
		queue_draw(0, 1);
		drain();

		// Largest texture on the largest quad, sampled at its far corner.
		write_reg(REG_ORIGIN_X, CFG_DATA_W'(-1024));
		write_reg(REG_ORIGIN_Y, CFG_DATA_W'(-1280));
		write_reg(REG_QUAD_W, 32'd2047);
		write_reg(REG_QUAD_H, 32'd2047);
		write_reg(REG_TEX_W, 32'd64);
		write_reg(REG_TEX_H, 32'd64);
		queue_draw(2046, 2046);
		queue_draw(1024, 1280);
		drain();
		directed_words = words_queued;

		// Random phases: a fresh setting of every register, then a batch of words.
		while (words_queued - directed_words < RANDOM_WORDS) begin
			pick = $urandom_range(0, 9);
			write_reg(REG_DRAW_MODE, CFG_DATA_W'((pick < 2) ? MODE_FILL :
				(pick < 4) ? MODE_BORDER : (pick < 9) ? MODE_IMAGE : MODE_UNUSED));
			write_reg(REG_FILL_COLOR, CFG_DATA_W'($urandom));
			for (int axis = 0; axis < 2; axis++) begin
				pick = $urandom_range(0, 7);
				if (pick == 0)
					dx = $urandom_range(0, 1) ? -2048 : 2047;
				else if (pick == 1)
					dx = int'($urandom_range(0, 4095)) - 2048;
				else
					dx = int'($urandom_range(0, 1040)) - 48;
				write_reg(axis ? REG_ORIGIN_Y : REG_ORIGIN_X, CFG_DATA_W'(dx));
				pick = $urandom_range(0, 9);
				if (pick == 0)
					dy = 0;
				else if (pick == 1)
					dy = 2047;
				else if (pick == 2)
					dy = $urandom_range(1, 2047);
				else
					dy = $urandom_range(1, 48);
				write_reg(axis ? REG_QUAD_H : REG_QUAD_W, CFG_DATA_W'(dy));
				pick = $urandom_range(0, 5);
				if (pick == 0)
					dy = $urandom_range(0, 127);
				else if (pick == 1)
					dy = TEX_DIM_MAX;
				else
					dy = $urandom_range(1, 16);
				write_reg(axis ? REG_TEX_H : REG_TEX_W, CFG_DATA_W'(dy));
			end

			n_items = $urandom_range(40, 140);
			repeat (n_items) begin
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					queue_load(ADDR_W'($urandom), random_texel());
				end else if (pick < 20) begin
					queue_draw($urandom_range(0, 2047), $urandom_range(0, 2047));
				end else if (pick < 30) begin
					// Offsets on the first, last and first-outside column and row.
					dx = ($urandom_range(0, 2) == 0) ? 0 :
						int'(quad_w_r) - int'($urandom_range(0, 1));
					dy = ($urandom_range(0, 2) == 0) ? 0 :
						int'(quad_h_r) - int'($urandom_range(0, 1));
					queue_draw((dx < 0) ? 0 : dx, (dy < 0) ? 0 : dy);
				end else begin
					queue_draw($urandom_range(0, int'(quad_w_r)), $urandom_range(0, int'(quad_h_r)));
				end
			end
			drain();
		end

		if (mismatch_count == 0 && exp_writes.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sbck_pkg.sv
rtl/sbck_in_if.sv
rtl/sbck_out_if.sv
rtl/sbck_div.sv
rtl/sbck_ctrl.sv
rtl/sbck_dp.sv
rtl/scaled_sprite_blit_color_key_core.sv
tb/sv/tb_top.sv
